// ----- hdl/mwse_pkg.sv -----
`timescale 1ns / 1ps
package mwse_pkg;

	localparam int HEADER_BYTES_DEF    = 192;
	localparam int MAX_IMAGE_BYTES_DEF = 262144;

	localparam int KEY_W  = 32;
	localparam int CRC_W  = 16;
	localparam int SIZE_W = 19;
	localparam int PAD_W  = SIZE_W + 1;
	localparam int OFF_W  = 21;
	localparam int CNT_W  = 5;

	localparam logic [KEY_W-1:0]  KEY_XOR    = 32'h7365646F;
	localparam logic [KEY_W-1:0]  LCG_MUL    = 32'h6177614B;
	localparam logic [KEY_W-1:0]  STREAM_XOR = 32'h20796220;
	localparam logic [KEY_W-1:0]  ADDR_BASE  = 32'h02000000;
	localparam logic [CRC_W-1:0]  CRC_INIT   = 16'h15A0;
	localparam logic [CRC_W-1:0]  CRC_POLY   = 16'hA1C1;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 19'd262144;

	localparam logic [0:0] REG_KEY  = 1'b0;
	localparam logic [0:0] REG_SIZE = 1'b1;

	localparam logic [1:0] WT_KEY  = 2'd0;
	localparam logic [1:0] WT_DATA = 2'd1;
	localparam logic [1:0] WT_CRC  = 2'd2;

	typedef struct packed {
		logic init;
		logic start;
	} crc_ctl_t;

	typedef struct packed {
		logic load;
		logic step;
	} lcg_ctl_t;

	function automatic logic [KEY_W-1:0] swap32(input logic [KEY_W-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	// Handshake key for a padded size, already in transmit byte order.
	function automatic logic [KEY_W-1:0] hs_key(input logic [PAD_W-1:0] size);
		logic [17:0]      d;
		logic [14:0]      s;
		logic [KEY_W-1:0] b;
		logic [7:0]       sum;
		logic [KEY_W-1:0] m;
		d   = size[17:0] - 18'h200;
		s   = d[17:3];
		b   = 32'h0038_0000 | (32'(s[14]) << 16) | (32'(s[13:7]) << 8) | 32'(s[6:0]);
		sum = b[7:0] + b[15:8] + b[23:16];
		m   = {sum, b[23:0]} | 32'h80808080;
		return m ^ (m[9] ? swap32(KEY_XOR) : LCG_MUL);
	endfunction

endpackage

// ----- hdl/mwse_crc.sv -----
`timescale 1ns / 1ps
module mwse_crc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mwse_pkg::crc_ctl_t            ctl,
	input  logic [mwse_pkg::KEY_W-1:0]    word,
	output logic                          busy,
	output logic [mwse_pkg::CRC_W-1:0]    crc
);
	import mwse_pkg::*;

	logic [CRC_W-1:0] crc_q;
	logic [KEY_W-1:0] val_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             fb;

	assign fb   = crc_q[0] ^ val_q[0];
	assign busy = busy_q;
	assign crc  = crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctl.init) begin
			crc_q  <= CRC_INIT;
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q  <= (crc_q >> 1) ^ (fb ? CRC_POLY : '0);
			cnt_q  <= cnt_q + CNT_W'(1);
			if (&cnt_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			val_q <= word;
		end else if (busy_q) begin
			val_q <= val_q >> 1;
		end
	end

endmodule

// ----- hdl/mwse_lcg.sv -----
`timescale 1ns / 1ps
module mwse_lcg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mwse_pkg::lcg_ctl_t          ctl,
	input  logic [mwse_pkg::KEY_W-1:0]  seed,
	output logic [mwse_pkg::KEY_W-1:0]  key
);
	import mwse_pkg::*;

	logic [KEY_W-1:0] key_q;

	assign key = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (ctl.load) begin
			key_q <= seed;
		end else if (ctl.step) begin
			key_q <= key_q * LCG_MUL + 32'd1;
		end
	end

endmodule

// ----- hdl/multiboot_word_stream_encryptor.sv -----
`timescale 1ns / 1ps
// Encrypts an upload image one item at a time. A begin item goes to S_HS,
// which loads the handshake key for output. A data item waits in S_CRC while
// the CRC unit shifts one bit of the word per cycle and the key step runs on
// a single 32x32 multiplier alongside; S_DOUT then loads its encrypted word.
// After the final data item, or after the key if the padded size is no
// larger than the header, S_CKEY makes one more key step and S_COUT loads
// the encrypted CRC word. The block takes no new item while an item is being
// worked on, and a result waits in the output register until it is taken.
// Data items outside a session are accepted and give no result.
module multiboot_word_stream_encryptor #(
	parameter int HEADER_BYTES    = mwse_pkg::HEADER_BYTES_DEF,
	parameter int MAX_IMAGE_BYTES = mwse_pkg::MAX_IMAGE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [mwse_pkg::KEY_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic [mwse_pkg::KEY_W-1:0]  data_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mwse_pkg::KEY_W-1:0]  out_word,
	output logic [1:0]                  word_type,
	output logic                        last
);
	import mwse_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_HS   = 6'b000010,
		S_CRC  = 6'b000100,
		S_DOUT = 6'b001000,
		S_CKEY = 6'b010000,
		S_COUT = 6'b100000
	} state_t;

	localparam logic [OFF_W:0]   MAX_V = (OFF_W + 1)'(MAX_IMAGE_BYTES);
	localparam logic [OFF_W-1:0] HDR_V = OFF_W'(HEADER_BYTES);

	state_t            state_q;
	logic [KEY_W-1:0]  key_raw_q;
	logic [SIZE_W-1:0] image_size_q;
	logic [PAD_W-1:0]  padded_q;
	logic [OFF_W-1:0]  offset_q;
	logic              active_q;
	logic [KEY_W-1:0]  data_q;

	logic [KEY_W-1:0]  out_word_q;
	logic [1:0]        word_type_q;
	logic              last_q;
	logic              out_valid_q;

	crc_ctl_t          crc_ctl;
	lcg_ctl_t          lcg_ctl;
	logic              crc_busy;
	logic [CRC_W-1:0]  crc_val;
	logic [KEY_W-1:0]  key;

	logic              in_acc;
	logic              slot_free;
	logic              load;
	logic [SIZE_W-1:0] size_clamped;
	logic [PAD_W-1:0]  padded_next;
	logic [OFF_W-1:0]  offset_inc;
	logic [KEY_W-1:0]  enc_word;
	logic [KEY_W-1:0]  enc_src;
	logic [KEY_W-1:0]  addr_neg;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign size_clamped = ((OFF_W + 1)'(image_size_q) > MAX_V) ? MAX_V[SIZE_W-1:0] :
		image_size_q;
	assign padded_next  = ({1'b0, size_clamped} + PAD_W'(7)) & ~PAD_W'(7);
	assign offset_inc   = offset_q + OFF_W'(4);

	assign enc_src  = (state_q == S_COUT) ? {padded_q[15:0], crc_val} : data_q;
	assign addr_neg = 32'd0 - (KEY_W'(offset_q) + ADDR_BASE);
	assign enc_word = enc_src ^ key ^ addr_neg ^ STREAM_XOR;

	assign load = slot_free && ((state_q == S_HS) || (state_q == S_DOUT) || (state_q == S_COUT));

	always_comb begin
		crc_ctl.init  = in_acc && !kind;
		crc_ctl.start = in_acc && kind && active_q;
		lcg_ctl.load  = in_acc && !kind;
		lcg_ctl.step  = (in_acc && kind && active_q) || (state_q == S_CKEY);
	end

	mwse_crc u_crc (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (crc_ctl),
		.word  (data_word),
		.busy  (crc_busy),
		.crc   (crc_val)
	);

	mwse_lcg u_lcg (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (lcg_ctl),
		.seed  (swap32(key_raw_q ^ KEY_XOR)),
		.key   (key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_raw_q    <= '0;
			image_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY:  key_raw_q    <= cfg_wdata;
				REG_SIZE: image_size_q <= cfg_wdata[SIZE_W-1:0];
				default:  key_raw_q    <= key_raw_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			padded_q <= '0;
			offset_q <= HDR_V;
			active_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && !kind) begin
						padded_q <= padded_next;
						offset_q <= HDR_V;
						active_q <= 1'b1;
						state_q  <= S_HS;
					end else if (in_acc && active_q) begin
						state_q <= S_CRC;
					end
				end
				S_HS: begin
					if (slot_free) begin
						state_q <= (offset_q >= OFF_W'(padded_q)) ? S_CKEY : S_IDLE;
					end
				end
				S_CRC: begin
					if (!crc_busy) begin
						state_q <= S_DOUT;
					end
				end
				S_DOUT: begin
					if (slot_free) begin
						offset_q <= offset_inc;
						state_q  <= (offset_inc >= OFF_W'(padded_q)) ? S_CKEY : S_IDLE;
					end
				end
				S_CKEY: begin
					state_q <= S_COUT;
				end
				S_COUT: begin
					if (slot_free) begin
						active_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && kind) begin
			data_q <= data_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			case (state_q)
				S_HS: begin
					out_word_q  <= hs_key(padded_q);
					word_type_q <= WT_KEY;
					last_q      <= 1'b0;
				end
				S_DOUT: begin
					out_word_q  <= enc_word;
					word_type_q <= WT_DATA;
					last_q      <= 1'b0;
				end
				default: begin
					out_word_q  <= enc_word;
					word_type_q <= WT_CRC;
					last_q      <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign word_type = word_type_q;
	assign last      = last_q;

	a_last_only_on_crc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (word_type == WT_CRC)))
		else $error("last flag does not match the CRC word type");

	a_idle_data_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && kind && !active_q) |=> (state_q == S_IDLE && !active_q))
		else $error("data item outside a session started work");

	a_crc_closes_session: assert property (@(posedge clk) disable iff (!arst_n)
		(load && state_q == S_COUT) |=> !active_q)
		else $error("session still open after the CRC word");

	a_crc_done_before_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DOUT) |-> !crc_busy)
		else $error("data word presented before the CRC update finished");

endmodule
